@@ src/source_token_scanner_top_defines.svh @@
// assertion helpers for the scanner top module
`ifndef SOURCE_TOKEN_SCANNER_TOP_DEFINES_SVH
`define SOURCE_TOKEN_SCANNER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define STS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define STS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/sts_pkg.sv @@
package sts_pkg;

  localparam int FIELD_BITS = 24;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = 2;
  localparam int CNT_BITS   = 3;

  typedef enum logic [2:0] {
    TOK_BREAK = 3'd0,
    TOK_WORD  = 3'd1,
    TOK_INT   = 3'd2,
    TOK_HEX   = 3'd3,
    TOK_BIN   = 3'd4,
    TOK_FRAC  = 3'd5,
    TOK_END   = 3'd6,
    TOK_ERR   = 3'd7
  } tok_type_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_UNKNOWN = 3'd1,
    ERR_DOT     = 3'd2,
    ERR_DDOT    = 3'd3,
    ERR_HEX     = 3'd4,
    ERR_BIN     = 3'd5
  } err_code_t;

  typedef struct packed {
    tok_type_t             kind;
    err_code_t             code;
    logic [FIELD_BITS-1:0] start;
    logic [FIELD_BITS-1:0] stop;
    logic                  last;
  } result_t;

  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_US    = 8'h5f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UZ    = 8'h5a;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_US;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
  endfunction

  function automatic logic is_bin(input logic [7:0] c);
    return c == CH_0 || c == CH_1;
  endfunction

endpackage

@@ src/source_token_scanner_top.sv @@
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+--------------------------------------
// char     | in        | char_valid/char_stall | char_code, end_of_input
// token    | out       | token_valid/token_stall | token_type, error_code, token_start,
//          |           |                      | token_end, last_result
// one character request is scanned per cycle while char_stall is low; its results
// land in a 4-entry result queue in the same edge and leave one per cycle on the
// token side while token_stall is low; a request that yields two results leaves
// them one at a time; char_stall rises while fewer than two queue slots are free
// rst clears the scan mode, position, token head and the queue
`include "source_token_scanner_top_defines.svh"

module source_token_scanner_top #(
  parameter int POS_BITS = 24
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] char_code,
  input  logic       end_of_input,
  output logic       token_valid,
  input  logic       token_stall,
  output logic [2:0] token_type,
  output logic [2:0] error_code,
  output logic [sts_pkg::FIELD_BITS-1:0] token_start,
  output logic [sts_pkg::FIELD_BITS-1:0] token_end,
  output logic       last_result
);
  import sts_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE = 4'd0,
    M_GAP  = 4'd1,
    M_WORD = 4'd2,
    M_ZERO = 4'd3,
    M_INT  = 4'd4,
    M_HEXP = 4'd5,
    M_HEX  = 4'd6,
    M_BINP = 4'd7,
    M_BIN  = 4'd8,
    M_DOT  = 4'd9,
    M_FRAC = 4'd10,
    M_HALT = 4'd11
  } mode_t;

  mode_t               mode, mode_next;
  logic [POS_BITS-1:0] position, position_next;
  logic [POS_BITS-1:0] token_head, token_head_next;
  logic [POS_BITS-1:0] pos_prev;

  result_t             fifo_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count, count_next;

  logic [FIELD_BITS-1:0] pos_lo, prev_lo, head_lo;

  logic      accept, pop;
  logic      fin, restart, err, endr;
  err_code_t ecode;
  tok_type_t fin_type;
  result_t   res0, res1, tok_res, tail_res;
  logic [1:0] n_res;

  assign pos_prev = position - 1'b1;

  // outputs keep the low field bits of the position, zero-extended when POS_BITS is narrower
  generate
    if (POS_BITS >= FIELD_BITS) begin : g_trunc
      assign pos_lo  = position[FIELD_BITS-1:0];
      assign prev_lo = pos_prev[FIELD_BITS-1:0];
      assign head_lo = token_head[FIELD_BITS-1:0];
    end else begin : g_ext
      assign pos_lo  = {{(FIELD_BITS-POS_BITS){1'b0}}, position};
      assign prev_lo = {{(FIELD_BITS-POS_BITS){1'b0}}, pos_prev};
      assign head_lo = {{(FIELD_BITS-POS_BITS){1'b0}}, token_head};
    end
  endgenerate

  assign char_stall  = count > CNT_BITS'(FIFO_DEPTH - 2);
  assign accept      = char_valid && !char_stall;
  assign token_valid = count != '0;
  assign pop         = token_valid && !token_stall;

  always_comb begin
    mode_next       = mode;
    position_next   = position;
    token_head_next = token_head;
    fin     = 1'b0;
    restart = 1'b0;
    err     = 1'b0;
    endr    = 1'b0;
    ecode   = ERR_NONE;

    if (mode == M_HALT) begin
      mode_next = M_HALT;
    end else if (end_of_input) begin
      mode_next = M_HALT;
      case (mode)
        M_HEXP: begin
          err = 1'b1; ecode = ERR_HEX;
        end
        M_BINP: begin
          err = 1'b1; ecode = ERR_BIN;
        end
        M_DOT: begin
          err = 1'b1; ecode = ERR_DOT;
        end
        M_IDLE: begin
          endr = 1'b1;
        end
        default: begin
          fin = 1'b1; endr = 1'b1;
        end
      endcase
    end else begin
      position_next = position + 1'b1;
      case (mode)
        M_IDLE: restart = 1'b1;
        M_GAP:  if (!is_space(char_code)) begin fin = 1'b1; restart = 1'b1; end
        M_WORD: if (!is_word(char_code)) begin fin = 1'b1; restart = 1'b1; end
        M_ZERO: begin
          if (is_digit(char_code)) mode_next = M_INT;
          else if (char_code == CH_X) mode_next = M_HEXP;
          else if (char_code == CH_B) mode_next = M_BINP;
          else if (char_code == CH_DOT) mode_next = M_DOT;
          else begin fin = 1'b1; restart = 1'b1; end
        end
        M_INT: begin
          if (char_code == CH_DOT) mode_next = M_DOT;
          else if (!is_digit(char_code)) begin fin = 1'b1; restart = 1'b1; end
        end
        M_HEXP: begin
          if (is_hex(char_code)) mode_next = M_HEX;
          else begin err = 1'b1; ecode = ERR_HEX; end
        end
        M_HEX:  if (!is_hex(char_code)) begin fin = 1'b1; restart = 1'b1; end
        M_BINP: begin
          if (is_bin(char_code)) mode_next = M_BIN;
          else begin err = 1'b1; ecode = ERR_BIN; end
        end
        M_BIN:  if (!is_bin(char_code)) begin fin = 1'b1; restart = 1'b1; end
        M_DOT: begin
          if (is_digit(char_code)) mode_next = M_FRAC;
          else begin err = 1'b1; ecode = ERR_DOT; end
        end
        M_FRAC: begin
          if (char_code == CH_DOT) begin err = 1'b1; ecode = ERR_DDOT; end
          else if (!is_digit(char_code)) begin fin = 1'b1; restart = 1'b1; end
        end
        default: mode_next = M_HALT;
      endcase

      // a char in idle or ending a token opens the next one; non-newline spaces idle
      if (restart) begin
        if (is_space(char_code)) begin
          if (char_code == CH_NL) begin
            mode_next = M_GAP; token_head_next = position;
          end else begin
            mode_next = M_IDLE;
          end
        end else if (is_alpha(char_code) || char_code == CH_US) begin
          mode_next = M_WORD; token_head_next = position;
        end else if (char_code == CH_0) begin
          mode_next = M_ZERO; token_head_next = position;
        end else if (is_digit(char_code)) begin
          mode_next = M_INT; token_head_next = position;
        end else begin
          err = 1'b1; ecode = ERR_UNKNOWN;
        end
      end
      if (err) mode_next = M_HALT;
    end
  end

  always_comb begin
    case (mode)
      M_GAP:         fin_type = TOK_BREAK;
      M_WORD:        fin_type = TOK_WORD;
      M_ZERO, M_INT: fin_type = TOK_INT;
      M_HEX:         fin_type = TOK_HEX;
      M_BIN:         fin_type = TOK_BIN;
      default:       fin_type = TOK_FRAC;
    endcase
  end

  always_comb begin
    tok_res  = '{kind: fin_type, code: ERR_NONE, start: head_lo, stop: prev_lo,
                 last: !(err || endr)};
    tail_res = '{kind: err ? TOK_ERR : TOK_END, code: ecode, start: pos_lo,
                 stop: pos_lo, last: 1'b1};
    res0  = fin ? tok_res : tail_res;
    res1  = tail_res;
    n_res = {1'b0, fin} + {1'b0, err || endr};
  end

  always_comb begin
    count_next = count;
    if (accept) count_next = count_next + CNT_BITS'(n_res);
    if (pop)    count_next = count_next - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      position   <= '0;
      token_head <= '0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else begin
      if (accept) begin
        mode       <= mode_next;
        position   <= position_next;
        token_head <= token_head_next;
        wr_ptr     <= wr_ptr + PTR_BITS'(n_res);
      end
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) fifo_q[wr_ptr] <= res0;
    if (accept && n_res == 2'd2) fifo_q[wr_ptr + 1'b1] <= res1;
  end

  assign token_type  = fifo_q[rd_ptr].kind;
  assign error_code  = fifo_q[rd_ptr].code;
  assign token_start = fifo_q[rd_ptr].start;
  assign token_end   = fifo_q[rd_ptr].stop;
  assign last_result = fifo_q[rd_ptr].last;

  `STS_ASSERT_NOW(a_count_depth, 1'b1, count <= CNT_BITS'(FIFO_DEPTH), "result queue overflow")
  `STS_ASSERT_NOW(a_pair_queued, token_valid && !last_result, count >= CNT_BITS'(2),
    "first result of a pair shown without its partner queued")
  `STS_ASSERT_NEXT(a_halt_sticks, accept && mode == M_HALT, mode == M_HALT,
    "scanner left halt without reset")
  `STS_ASSERT_NEXT(a_end_halts, accept && end_of_input, mode == M_HALT,
    "end of input did not halt the scanner")

endmodule
